/* hdl/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    // Width of every coordinate field on the ports.
    localparam int FIELD_BITS = 6;
    // Decision variable width: |d| stays below 4 * 2^FIELD_BITS.
    localparam int D_BITS     = FIELD_BITS + 4;

    typedef logic [FIELD_BITS-1:0]    coord_t;
    typedef logic signed [D_BITS-1:0] dvar_t;

    // One classified line, ready for the stepper.
    typedef struct packed {
        coord_t maj0;    // first major coordinate
        coord_t maj1;    // last major coordinate
        coord_t min0;    // first minor coordinate
        logic   swap;    // major axis is y
        logic   up;      // minor axis rises
        dvar_t  d0;      // initial decision value
        dvar_t  inc_lt;  // increment when d < 0
        dvar_t  inc_ge;  // increment when d >= 0
    } line_cmd_t;

    function automatic dvar_t to_dvar(coord_t v);
        return $signed({{(D_BITS-FIELD_BITS){1'b0}}, v});
    endfunction

endpackage

/* hdl/midpoint_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Rasterizes one line segment per item into its pixels, one pixel per result.
// ----------------------------------------------------------------------------
// Push a segment (two endpoints in tile coordinates) while full is low; pop
// pixels while empty is low. A segment yields 1 + max(|dx|, |dy|) pixels, the
// last one flagged with last. Vertical segments run bottom to top; all others
// run with x rising, or with y rising when the slope magnitude exceeds one.
// The stepper emits one pixel per cycle unless the output register is held
// by a stalled pop; a segment yields at most 64 pixels, and consecutive
// segments follow with no gap. The front classifies a segment in the cycle it
// is pushed and parks it in a two-entry queue, so up to two segments can wait
// behind the one being drawn. Input bits above COORD_BITS are ignored.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mlr_pkg::coord_t x_start,
    input  mlr_pkg::coord_t y_start,
    input  mlr_pkg::coord_t x_end,
    input  mlr_pkg::coord_t y_end,
    input  logic            pop,
    output logic            empty,
    output mlr_pkg::coord_t pixel_x,
    output mlr_pkg::coord_t pixel_y,
    output logic            last
);

    mlr_pkg::line_cmd_t front_cmd;
    mlr_pkg::line_cmd_t q_data;
    logic               q_valid;
    logic               q_pop;

    // classify the incoming segment: endpoint order, major axis, setup of d
    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .cmd     (front_cmd)
    );

    // decouples the front from the stepper; full back-pressures push
    mlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    // walks the major axis, one pixel per cycle unless pop stalls, into the output register
    mlr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .last    (last)
    );

endmodule

/* hdl/mlr_front.sv */
// ----------------------------------------------------------------------------
// mlr_front
// Orders the endpoints, picks the major axis and direction, and sets up the
// decision variable and its two increments for one line.
// ----------------------------------------------------------------------------
module mlr_front #(
    parameter int COORD_BITS = 6
) (
    input  mlr_pkg::coord_t    x_start,
    input  mlr_pkg::coord_t    y_start,
    input  mlr_pkg::coord_t    x_end,
    input  mlr_pkg::coord_t    y_end,
    output mlr_pkg::line_cmd_t cmd
);

    localparam mlr_pkg::coord_t COORD_MASK =
        mlr_pkg::coord_t'((1 << COORD_BITS) - 1);

    mlr_pkg::coord_t x0, y0, x1, y1;
    mlr_pkg::coord_t xa, ya, xb, yb;
    mlr_pkg::coord_t dx, ady;
    mlr_pkg::coord_t maj0, maj1, min0, min1;
    logic            dy_up;
    logic            swap, up;
    mlr_pkg::dvar_t  a, b;

    always_comb
    begin
        x0 = x_start & COORD_MASK;
        y0 = y_start & COORD_MASK;
        x1 = x_end   & COORD_MASK;
        y1 = y_end   & COORD_MASK;

        // order so that x rises
        if (x0 > x1)
        begin
            xa = x1; ya = y1; xb = x0; yb = y0;
        end
        else
        begin
            xa = x0; ya = y0; xb = x1; yb = y1;
        end

        dx    = xb - xa;
        dy_up = (yb >= ya);
        ady   = dy_up ? (yb - ya) : (ya - yb);

        priority if (xa == xb)
        begin
            // vertical: bottom to top, minor axis never moves
            maj0 = (ya < yb) ? ya : yb;
            maj1 = (ya < yb) ? yb : ya;
            min0 = xa;
            min1 = xa;
            swap = 1'b1;
            up   = 1'b1;
        end
        else if (ady <= dx)
        begin
            maj0 = xa; maj1 = xb; min0 = ya; min1 = yb;
            swap = 1'b0;
            up   = dy_up;
        end
        else if (dy_up)
        begin
            maj0 = ya; maj1 = yb; min0 = xa; min1 = xb;
            swap = 1'b1;
            up   = 1'b1;
        end
        else
        begin
            maj0 = yb; maj1 = ya; min0 = xb; min1 = xa;
            swap = 1'b1;
            up   = 1'b0;
        end

        a = mlr_pkg::to_dvar(min0) - mlr_pkg::to_dvar(min1);
        b = mlr_pkg::to_dvar(maj1) - mlr_pkg::to_dvar(maj0);

        cmd.maj0   = maj0;
        cmd.maj1   = maj1;
        cmd.min0   = min0;
        cmd.swap   = swap;
        cmd.up     = up;
        // line function vanishes at the start point, so d0 is 2a +/- b
        cmd.d0     = up ? ((a <<< 1) + b) : ((a <<< 1) - b);
        cmd.inc_lt = up ? ((a + b) <<< 1) : (a <<< 1);
        cmd.inc_ge = up ? (a <<< 1) : ((a - b) <<< 1);
    end

endmodule

/* hdl/mlr_queue.sv */
// ----------------------------------------------------------------------------
// mlr_queue
// Two-entry queue of classified lines between front and stepper.
// ----------------------------------------------------------------------------
module mlr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  mlr_pkg::line_cmd_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output logic               rd_valid,
    output mlr_pkg::line_cmd_t rd_data
);

    mlr_pkg::line_cmd_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               do_wr, do_rd;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        rd_valid    = (count_reg != 2'd0);
        rd_data     = entry_reg[rd_ptr_reg];
        do_wr       = wr_en && !full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/mlr_back.sv */
// ----------------------------------------------------------------------------
// mlr_back
// Midpoint stepper: one pixel per cycle, unless stalled by pop, into a one-entry output register.
// ----------------------------------------------------------------------------
module mlr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  mlr_pkg::line_cmd_t q_data,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output mlr_pkg::coord_t    pixel_x,
    output mlr_pkg::coord_t    pixel_y,
    output logic               last
);

    logic               active_reg, active_next;
    mlr_pkg::line_cmd_t cmd_reg, cmd_next;
    mlr_pkg::coord_t    m_reg, m_next;
    mlr_pkg::coord_t    n_reg, n_next;
    mlr_pkg::dvar_t     d_reg, d_next;
    logic               out_valid_reg, out_valid_next;
    mlr_pkg::coord_t    px_reg, px_next;
    mlr_pkg::coord_t    py_reg, py_next;
    logic               last_reg, last_next;
    logic               emit, fin, load, neg;

    always_comb
    begin
        emit = active_reg && (!out_valid_reg || pop);
        fin  = (m_reg == cmd_reg.maj1);
        neg  = d_reg[mlr_pkg::D_BITS-1];
        // next line enters as soon as the current one emits its last pixel
        load = q_valid && (!active_reg || (emit && fin));
        q_pop = load;

        active_next    = active_reg;
        cmd_next       = cmd_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            px_next        = cmd_reg.swap ? n_reg : m_reg;
            py_next        = cmd_reg.swap ? m_reg : n_reg;
            last_next      = fin;
            m_next         = m_reg + mlr_pkg::coord_t'(1);
            if (neg)
            begin
                d_next = d_reg + cmd_reg.inc_lt;
                if (cmd_reg.up)
                begin
                    n_next = n_reg + mlr_pkg::coord_t'(1);
                end
            end
            else
            begin
                d_next = d_reg + cmd_reg.inc_ge;
                if (!cmd_reg.up)
                begin
                    n_next = n_reg - mlr_pkg::coord_t'(1);
                end
            end
            if (fin)
            begin
                active_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            active_next = 1'b1;
            cmd_next    = q_data;
            m_next      = q_data.maj0;
            n_next      = q_data.min0;
            d_next      = q_data.d0;
        end

        empty   = !out_valid_reg;
        pixel_x = px_reg;
        pixel_y = py_reg;
        last    = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        m_reg    <= m_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/mlr_checker.sv */
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
module mlr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            full,
    input logic            pop,
    input logic            empty,
    input mlr_pkg::coord_t pixel_x,
    input mlr_pkg::coord_t pixel_y,
    input logic            last
);

    // reset leaves nothing queued or shown
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("outputs not idle in reset");

    // a waiting pixel holds while not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_x) && $stable(pixel_y)
                              && $stable(last)))
        else $error("waiting pixel changed");

    // within a line the next pixel is ready right after a pop
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> !empty)
        else $error("gap inside a line");

    // consecutive pixels of a line are 8-neighbors and never repeat
    a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=>
            ((pixel_x == $past(pixel_x) || pixel_x == $past(pixel_x) + 6'd1
              || pixel_x == $past(pixel_x) - 6'd1)
             && (pixel_y == $past(pixel_y) || pixel_y == $past(pixel_y) + 6'd1
              || pixel_y == $past(pixel_y) - 6'd1)
             && !(pixel_x == $past(pixel_x) && pixel_y == $past(pixel_y))))
        else $error("pixels of a line not adjacent");

endmodule

bind midpoint_line_rasterizer mlr_checker u_checker (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
// Segments are pushed in random bursts. Each accepted item is traced in the
// bench with the same integer midpoint walk, giving its pixels in order. A
// checker compares every popped pixel with the oldest traced one. The pop
// side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int MAX_REPORTS  = 20;
    localparam int DRAIN_CYCLES = 100;   // quiet time to catch stray pixels

    typedef enum int {SEG_POINT, SEG_VERTICAL, SEG_SHALLOW, SEG_STEEP} seg_kind_t;

    typedef struct {
        mlr_pkg::coord_t x;
        mlr_pkg::coord_t y;
        logic            fin;
    } pixel_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    mlr_pkg::coord_t x_start = '0;
    mlr_pkg::coord_t y_start = '0;
    mlr_pkg::coord_t x_end = '0;
    mlr_pkg::coord_t y_end = '0;
    logic            pop = 1'b0;
    logic            empty;
    mlr_pkg::coord_t pixel_x;
    mlr_pkg::coord_t pixel_y;
    logic            last;

    pixel_t pixel_expect_q[$];
    int     error_cnt = 0;
    int     pixels_checked = 0;
    int     segments_sent = 0;
    int     kind_cnt[4] = '{default: 0};
    int     burst_left = 1;
    int     cycle_cnt = 0;

    midpoint_line_rasterizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .pop     (pop),
        .empty   (empty),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .last    (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a healthy run ends far below this.
    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
                $display("mismatch @%0t: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------------

    function automatic void queue_pixel(input int px, input int py, input bit fin);
        pixel_t p;
        p.x = mlr_pkg::coord_t'(px);
        p.y = mlr_pkg::coord_t'(py);
        p.fin = fin;
        pixel_expect_q.push_back(p);
    endfunction

    // Walk the major axis from maj0 up to maj1; the minor axis goes from min0
    // toward min1. D is twice the line function at the midpoint, so the half
    // pixel offset stays an exact odd integer.
    function automatic void step_major(input int maj0, input int maj1, input int min0,
                                       input int min1, input bit rising, input bit y_major);
        int a;
        int b;
        int c;
        int d;
        int m;
        int n;
        a = min0 - min1;
        b = maj1 - maj0;
        c = maj0 * min1 - min0 * maj1;
        d = 2 * a * (maj0 + 1) + b * (2 * min0 + (rising ? 1 : -1)) + 2 * c;
        n = min0;
        for (m = maj0; m <= maj1; m++)
        begin
            if (y_major)
                queue_pixel(n, m, m == maj1);
            else
                queue_pixel(m, n, m == maj1);
            if (d < 0)
            begin
                if (rising)
                begin
                    n++;
                    d += 2 * (a + b);
                end
                else
                    d += 2 * a;
            end
            else
            begin
                if (rising)
                    d += 2 * a;
                else
                begin
                    n--;
                    d += 2 * (a - b);
                end
            end
        end
    endfunction

    function automatic void trace_segment(input int xa, input int ya, input int xb,
                                          input int yb);
        int t;
        int dx;
        int dy;
        int ady;
        bit rising;
        if (xa == xb)
        begin
            // Vertical, including a single point: always bottom to top.
            kind_cnt[(ya == yb) ? SEG_POINT : SEG_VERTICAL]++;
            for (t = (ya < yb ? ya : yb); t <= (ya < yb ? yb : ya); t++)
                queue_pixel(xa, t, t == (ya < yb ? yb : ya));
            return;
        end
        if (xa > xb)
        begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        dx = xb - xa;
        dy = yb - ya;
        rising = (dy >= 0);
        ady = rising ? dy : -dy;
        if (ady <= dx)
        begin
            kind_cnt[SEG_SHALLOW]++;
            step_major(xa, xb, ya, yb, rising, 1'b0);
        end
        else
        begin
            kind_cnt[SEG_STEEP]++;
            if (rising)
                step_major(ya, yb, xa, xb, 1'b1, 1'b1);
            else
                step_major(yb, ya, xb, xa, 1'b0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pixel checker: every pop is matched against the oldest traced pixel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pixel_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                          pixel_x, pixel_y, last));
            else
            begin
                if (pixel_x !== pixel_expect_q[0].x)
                    report_mismatch($sformatf("pixel_x got %0d want %0d",
                                              pixel_x, pixel_expect_q[0].x));
                if (pixel_y !== pixel_expect_q[0].y)
                    report_mismatch($sformatf("pixel_y got %0d want %0d",
                                              pixel_y, pixel_expect_q[0].y));
                if (last !== pixel_expect_q[0].fin)
                    report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                              last, pixel_expect_q[0].fin,
                                              pixel_expect_q[0].x, pixel_expect_q[0].y));
                void'(pixel_expect_q.pop_front());
                pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pop side: the stall pattern changes with a randomly chosen mode, and each
    // mode bounds its stalls; one mode never stalls at all.
    // ------------------------------------------------------------------------
    initial
    begin : pop_pattern
        int max_stall;
        int stall_left;
        int mode_left;
        max_stall = 0;
        stall_left = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: max_stall = 0;
                    1: max_stall = 1;
                    2: max_stall = 3;
                    default: max_stall = 8;
                endcase
                mode_left = $urandom_range(64, 320);
            end
            mode_left--;
            if (stall_left == 0)
            begin
                pop <= 1'b1;
                stall_left = $urandom_range(0, max_stall);
            end
            else
            begin
                pop <= 1'b0;
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Push side
    // ------------------------------------------------------------------------

    // Gaps come between bursts only; push is lowered just when a gap follows,
    // so back-to-back items keep it high.
    task automatic pace_sender();
        int gap;
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = $urandom_range(0, 10);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 12);
            end
        end
    endtask

    // Called right after a rising edge; returns after the accepting edge and any gap that follows it.
    task automatic send_segment(input int xa, input int ya, input int xb, input int yb);
        begin
            push    <= 1'b1;
            x_start <= mlr_pkg::coord_t'(xa);
            y_start <= mlr_pkg::coord_t'(ya);
            x_end   <= mlr_pkg::coord_t'(xb);
            y_end   <= mlr_pkg::coord_t'(yb);
            @(posedge clk);
            while (full)
                @(posedge clk);
            trace_segment(xa, ya, xb, yb);
            segments_sent++;
            pace_sender();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Equal endpoints give one pixel with last set, at three corners and one inner point.
    task automatic test_single_points();
        begin
            send_segment(0, 0, 0, 0);
            send_segment(63, 63, 63, 63);
            send_segment(63, 0, 63, 0);
            send_segment(21, 42, 21, 42);
        end
    endtask

    // Full-length axis lines in both directions plus a short vertical one; vertical always goes up.
    task automatic test_axis_lines();
        begin
            send_segment(0, 0, 63, 0);
            send_segment(63, 63, 0, 63);
            send_segment(0, 0, 0, 63);
            send_segment(63, 63, 63, 0);
            send_segment(40, 5, 40, 6);
        end
    endtask

    // Slope magnitude exactly one stays x-major.
    task automatic test_diagonals();
        begin
            send_segment(0, 0, 63, 63);
            send_segment(63, 0, 0, 63);
            send_segment(63, 63, 0, 0);
            send_segment(0, 63, 63, 0);
        end
    endtask

    // One segment per octant, entered from both ends.
    task automatic test_octants();
        begin
            send_segment(0, 10, 63, 40);    // shallow rising
            send_segment(63, 40, 0, 10);
            send_segment(0, 50, 63, 3);     // shallow falling
            send_segment(63, 3, 0, 50);
            send_segment(10, 0, 40, 63);    // steep rising
            send_segment(40, 63, 10, 0);
            send_segment(50, 0, 3, 63);     // steep falling
            send_segment(3, 63, 50, 0);
            send_segment(7, 7, 8, 9);       // short steep
            send_segment(9, 8, 7, 7);       // short shallow
        end
    endtask

    // Mostly short segments around a random anchor, a few spanning the tile.
    task automatic test_random_segments(input int count);
        int i;
        int span;
        int xa;
        int ya;
        int xb;
        int yb;
        begin
            for (i = 0; i < count; i++)
            begin
                xa = $urandom_range(0, 63);
                ya = $urandom_range(0, 63);
                if ($urandom_range(0, 7) == 0)
                begin
                    xb = $urandom_range(0, 63);
                    yb = $urandom_range(0, 63);
                end
                else
                begin
                    span = $urandom_range(0, 12);
                    xb = xa + $urandom_range(0, 2 * span) - span;
                    yb = ya + $urandom_range(0, 2 * span) - span;
                    // Some axis-aligned ones so vertical and flat lines recur.
                    case ($urandom_range(0, 7))
                        0: xb = xa;
                        1: yb = ya;
                        default: ;
                    endcase
                    xb = (xb < 0) ? 0 : (xb > 63) ? 63 : xb;
                    yb = (yb < 0) ? 0 : (yb > 63) ? 63 : yb;
                end
                send_segment(xa, ya, xb, yb);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_points();
        test_axis_lines();
        test_diagonals();
        test_octants();
        test_random_segments(457);
        push <= 1'b0;

        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        // Catch any pixel the block emits beyond the traced ones.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pixel_expect_q.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", pixel_expect_q.size()));

        $display("run: %0d segments (%0d points, %0d vertical, %0d x-major, %0d y-major)",
                 segments_sent, kind_cnt[SEG_POINT], kind_cnt[SEG_VERTICAL],
                 kind_cnt[SEG_SHALLOW], kind_cnt[SEG_STEEP]);
        $display("run: %0d pixels compared in %0d cycles, %0d mismatches",
                 pixels_checked, cycle_cnt, error_cnt);
        if (error_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
